// ===== sv/stp_ramp_pkg.sv =====
`timescale 1ns / 1ps
// Package with the types and codes shared by the trapezoid ramp generator.
package stp_ramp_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned DIV_CNT_W = $clog2(PERIOD_W);

    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RESET    = 16'd200;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RESET    = 16'd2000;
    localparam logic [PERIOD_W-1:0] PERIOD_CHANGE_RESET = 16'd10;

    typedef enum logic [1:0] {
        CFG_PERIOD_MIN    = 2'd0,
        CFG_PERIOD_MAX    = 2'd1,
        CFG_PERIOD_CHANGE = 2'd2,
        CFG_HOMING_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_ZERO  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_TARGET = 2'd1,
        CAUSE_LIMIT  = 2'd2,
        CAUSE_HOME   = 2'd3
    } stop_cause_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PLAN_RAMP,
        S_PLAN_DECEL,
        S_STEP,
        S_RAMP,
        S_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COUNT_W-1:0] step_total;
        logic               move_dir;
        logic               home_switch;
        logic               limit_switch;
    } in_item_t;

    typedef struct packed {
        logic                      accepted;
        logic [1:0]                phase;
        logic [PERIOD_W-1:0]       timer_period;
        logic [PERIOD_W-2:0]       pulse_compare;
        logic signed [COUNT_W-1:0] axis_position;
        logic                      alarm;
        logic                      move_done;
        logic [1:0]                stop_cause;
        logic                      flush_queue;
    } out_item_t;

endpackage

// ===== sv/stepper_trapezoid_ramp.sv =====
`timescale 1ns / 1ps
// Top level of the trapezoidal step-period ramp generator for one stepper axis.
//
// This block tracks one stepper axis and hands back, for every transfer on the
// input channel, exactly one result transfer with the current timer period,
// the pulse compare value, the signed position and the stop status. A step
// tick that counts a step passes from its transfer through counting the step,
// checking the target, moving the period along the ramp and loading the result
// register before the result is offered. The tick that reaches the target skips
// the ramp step. For a start move the ramp length is twice the quotient
// (period_max - period_min) / period_change, which a restoring divider in the
// sequencer works out one quotient bit per cycle, followed by the planning
// states S_PLAN_RAMP and S_PLAN_DECEL that cap the ramp at half the move and
// place the decel point. A start with no ramp to work out (period_max not above
// period_min, or no period change) skips the divider. Clear alarm, zero
// position, refused starts, ticks while idle and ticks stopped by a switch go
// straight to loading the result register. The block holds in_stall high from
// a transfer until its result has been taken, so one item is in flight at a
// time. Configuration registers may be written only while no item is in
// flight.

module stepper_trapezoid_ramp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  stp_ramp_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output stp_ramp_pkg::out_item_t out_data,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);

    import stp_ramp_pkg::*;

    // Configuration registers.
    logic [PERIOD_W-1:0] period_min_reg;
    logic [PERIOD_W-1:0] period_max_reg;
    logic [PERIOD_W-1:0] period_change_reg;
    logic                homing_mode_reg;

    // Sequencer state.
    seq_state_t state_reg, state_next;

    // Axis state.
    phase_t              phase_reg, phase_next;
    logic                dir_reg, dir_next;
    logic [COUNT_W-1:0]  steps_done_reg, steps_done_next;
    logic [COUNT_W-1:0]  steps_goal_reg, steps_goal_next;
    logic [COUNT_W-1:0]  ramp_steps_reg, ramp_steps_next;
    logic [COUNT_W-1:0]  decel_point_reg, decel_point_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [COUNT_W-1:0]  position_reg, position_next;
    logic                alarm_reg, alarm_next;

    // Per-item status gathered while the item is worked on.
    logic                accepted_reg, accepted_next;
    logic                done_reg, done_next;
    stop_cause_t         cause_reg, cause_next;
    logic                flush_reg, flush_next;

    // Restoring divider: remainder, quotient shifting in, bit counter.
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Result register.
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic                in_fire;
    logic                start_ok;
    logic                has_ramp;
    logic [PERIOD_W:0]   div_trial;
    logic [PERIOD_W:0]   div_diff;
    logic [COUNT_W-1:0]  need_twice;
    logic [COUNT_W-1:0]  need_steps;
    logic [PERIOD_W-1:0] period_down;
    logic [PERIOD_W:0]   period_sum;
    logic [PERIOD_W-1:0] period_up;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A start is taken only from rest, with a nonzero count and no alarm.
    assign start_ok = (phase_reg == PH_IDLE) && (in_data.step_total != '0) && !alarm_reg;
    // A ramp exists only for an ordered pair of bounds and a nonzero change.
    assign has_ramp = (period_max_reg > period_min_reg) && (period_change_reg != '0);

    // One step of restoring division: shift in the next dividend bit, try the subtract.
    assign div_trial = {rem_reg, quo_reg[PERIOD_W-1]};
    assign div_diff  = div_trial - {1'b0, period_change_reg};

    // The quotient doubled is the ramp length; doubled again it is compared with the move.
    assign need_steps = {{(COUNT_W-PERIOD_W-1){1'b0}}, quo_reg, 1'b0};
    assign need_twice = {{(COUNT_W-PERIOD_W-2){1'b0}}, quo_reg, 2'b00};

    // Saturating period moves, then clamped to the configured bounds.
    always_comb
    begin
        if (period_reg > period_change_reg)
        begin
            period_down = period_reg - period_change_reg;
        end
        else
        begin
            period_down = '0;
        end
        if (period_down < period_min_reg)
        begin
            period_down = period_min_reg;
        end
    end

    assign period_sum = {1'b0, period_reg} + {1'b0, period_change_reg};

    always_comb
    begin
        if (period_sum[PERIOD_W])
        begin
            period_up = '1;
        end
        else
        begin
            period_up = period_sum[PERIOD_W-1:0];
        end
        if (period_up > period_max_reg)
        begin
            period_up = period_max_reg;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.action)
                        ACT_START:
                        begin
                            if (start_ok && has_ramp)
                            begin
                                state_next = S_DIV;
                            end
                            else if (start_ok)
                            begin
                                state_next = S_PLAN_RAMP;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        ACT_TICK:
                        begin
                            if ((phase_reg != PH_IDLE)
                                && !(in_data.limit_switch && dir_reg)
                                && !(in_data.home_switch && !dir_reg))
                            begin
                                state_next = S_STEP;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(PERIOD_W - 1))
                begin
                    state_next = S_PLAN_RAMP;
                end
            end
            S_PLAN_RAMP:  state_next = S_PLAN_DECEL;
            S_PLAN_DECEL: state_next = S_RESULT;
            S_STEP:
            begin
                if (steps_done_reg >= steps_goal_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_RAMP;
                end
            end
            S_RAMP:   state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer state.
    always_comb
    begin
        phase_next       = phase_reg;
        dir_next         = dir_reg;
        steps_done_next  = steps_done_reg;
        steps_goal_next  = steps_goal_reg;
        ramp_steps_next  = ramp_steps_reg;
        decel_point_next = decel_point_reg;
        period_next      = period_reg;
        position_next    = position_reg;
        alarm_next       = alarm_reg;
        accepted_next    = accepted_reg;
        done_next        = done_reg;
        cause_next       = cause_reg;
        flush_next       = flush_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    accepted_next = 1'b0;
                    done_next     = 1'b0;
                    cause_next    = CAUSE_NONE;
                    flush_next    = 1'b0;
                    case (in_data.action)
                        ACT_START:
                        begin
                            if (start_ok)
                            begin
                                accepted_next   = 1'b1;
                                dir_next        = in_data.move_dir;
                                steps_goal_next = in_data.step_total;
                                steps_done_next = '0;
                                phase_next      = PH_ACCEL;
                                period_next     = period_max_reg;
                                rem_next        = '0;
                                div_cnt_next    = '0;
                                if (has_ramp)
                                begin
                                    quo_next = period_max_reg - period_min_reg;
                                end
                                else
                                begin
                                    quo_next = '0;
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            alarm_next = 1'b0;
                        end
                        ACT_ZERO:
                        begin
                            position_next = '0;
                        end
                        ACT_TICK:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                if (in_data.limit_switch && dir_reg)
                                begin
                                    alarm_next = 1'b1;
                                    flush_next = 1'b1;
                                    cause_next = CAUSE_LIMIT;
                                    phase_next = PH_IDLE;
                                end
                                else if (in_data.home_switch && !dir_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    cause_next = CAUSE_HOME;
                                    if (!homing_mode_reg)
                                    begin
                                        alarm_next = 1'b1;
                                        flush_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    steps_done_next = steps_done_reg + 1'b1;
                                    if (dir_reg)
                                    begin
                                        position_next = position_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        position_next = position_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (!div_diff[PERIOD_W])
                begin
                    rem_next = div_diff[PERIOD_W-1:0];
                    quo_next = {quo_reg[PERIOD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[PERIOD_W-1:0];
                    quo_next = {quo_reg[PERIOD_W-2:0], 1'b0};
                end
            end
            S_PLAN_RAMP:
            begin
                if (need_twice > steps_goal_reg)
                begin
                    ramp_steps_next = steps_goal_reg >> 1;
                end
                else
                begin
                    ramp_steps_next = need_steps;
                end
            end
            S_PLAN_DECEL:
            begin
                decel_point_next = steps_goal_reg - ramp_steps_reg;
            end
            S_STEP:
            begin
                if (steps_done_reg >= steps_goal_reg)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                    cause_next = CAUSE_TARGET;
                end
            end
            S_RAMP:
            begin
                case (phase_reg)
                    PH_ACCEL:
                    begin
                        if (period_reg > period_min_reg)
                        begin
                            period_next = period_down;
                        end
                        if (steps_done_reg >= ramp_steps_reg)
                        begin
                            if (steps_done_reg >= decel_point_reg)
                            begin
                                phase_next = PH_DECEL;
                            end
                            else
                            begin
                                phase_next = PH_CRUISE;
                            end
                        end
                    end
                    PH_CRUISE:
                    begin
                        if (steps_done_reg >= decel_point_reg)
                        begin
                            phase_next = PH_DECEL;
                        end
                    end
                    PH_DECEL:
                    begin
                        if (period_reg < period_max_reg)
                        begin
                            period_next = period_up;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RESULT:
            begin
                out_next.accepted      = accepted_reg;
                out_next.phase         = phase_reg;
                out_next.timer_period  = period_reg;
                out_next.pulse_compare = period_reg[PERIOD_W-1:1];
                out_next.axis_position = position_reg;
                out_next.alarm         = alarm_reg;
                out_next.move_done     = done_reg;
                out_next.stop_cause    = cause_reg;
                out_next.flush_queue   = flush_reg;
                out_valid_next         = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control and axis registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_IDLE;
            dir_reg         <= 1'b0;
            steps_done_reg  <= '0;
            steps_goal_reg  <= '0;
            ramp_steps_reg  <= '0;
            decel_point_reg <= '0;
            period_reg      <= '0;
            position_reg    <= '0;
            alarm_reg       <= 1'b0;
            accepted_reg    <= 1'b0;
            done_reg        <= 1'b0;
            cause_reg       <= CAUSE_NONE;
            flush_reg       <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            dir_reg         <= dir_next;
            steps_done_reg  <= steps_done_next;
            steps_goal_reg  <= steps_goal_next;
            ramp_steps_reg  <= ramp_steps_next;
            decel_point_reg <= decel_point_next;
            period_reg      <= period_next;
            position_reg    <= position_next;
            alarm_reg       <= alarm_next;
            accepted_reg    <= accepted_next;
            done_reg        <= done_next;
            cause_reg       <= cause_next;
            flush_reg       <= flush_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Divider working registers and the result payload need no reset.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        out_reg <= out_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_min_reg    <= PERIOD_MIN_RESET;
            period_max_reg    <= PERIOD_MAX_RESET;
            period_change_reg <= PERIOD_CHANGE_RESET;
            homing_mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PERIOD_MIN:    period_min_reg    <= cfg_data;
                CFG_PERIOD_MAX:    period_max_reg    <= cfg_data;
                CFG_PERIOD_CHANGE: period_change_reg <= cfg_data;
                CFG_HOMING_MODE:   homing_mode_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // A taken start always leaves the axis accelerating.
    a_start_accel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accepted |-> out_data.phase == PH_ACCEL)
        else $error("accepted start without accelerate phase");

    // Reaching the target stops the axis and reports the target as the cause.
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.move_done
            |-> out_data.phase == PH_IDLE && out_data.stop_cause == CAUSE_TARGET)
        else $error("move done without idle phase and target cause");

    // A queue flush only comes with a raised alarm.
    a_flush_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.flush_queue |-> out_data.alarm)
        else $error("flush requested without alarm");

    // No result is offered on the cycle right after an input transfer.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result offered too early");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stepper trapezoid ramp generator.

module testbench;

    import stp_ramp_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_PERIOD_MIN;
    logic [15:0] cfg_data  = '0;

    stepper_trapezoid_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Items waiting to be driven, and the axis results still owed by the block.
    in_item_t  pending_items[$];
    out_item_t axis_results_due[$];

    logic in_taken    = 1'b0;
    int   items_sent  = 0;
    int   fault_count = 0;

    // Shadow copy of the configuration registers, updated when a write lands.
    logic [15:0] reg_min    = PERIOD_MIN_RESET;
    logic [15:0] reg_max    = PERIOD_MAX_RESET;
    logic [15:0] reg_chg    = PERIOD_CHANGE_RESET;
    logic        reg_homing = 1'b0;

    // Shadow copy of the axis state.
    phase_t      ax_phase  = PH_IDLE;
    logic        ax_dir    = 1'b0;
    logic [31:0] ax_done   = '0;
    logic [31:0] ax_goal   = '0;
    logic [31:0] ax_ramp   = '0;
    logic [31:0] ax_decel  = '0;
    logic [15:0] ax_period = '0;
    logic [31:0] ax_pos    = '0;
    logic        ax_alarm  = 1'b0;

    // Moves the period one step along the trapezoid and advances the phase after a counted step.
    function automatic void ramp_period();
        logic [16:0] sum;
        case (ax_phase)
            PH_ACCEL:
            begin
                if (ax_period > reg_min)
                begin
                    ax_period = (ax_period > reg_chg) ? ax_period - reg_chg : 16'd0;
                    if (ax_period < reg_min)
                        ax_period = reg_min;
                end
                if (ax_done >= ax_ramp)
                    ax_phase = (ax_done >= ax_decel) ? PH_DECEL : PH_CRUISE;
            end
            PH_CRUISE:
            begin
                if (ax_done >= ax_decel)
                    ax_phase = PH_DECEL;
            end
            PH_DECEL:
            begin
                if (ax_period < reg_max)
                begin
                    sum = {1'b0, ax_period} + {1'b0, reg_chg};
                    ax_period = sum[16] ? 16'hFFFF : sum[15:0];
                    if (ax_period > reg_max)
                        ax_period = reg_max;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Applies one item to the shadow axis and returns the result it should produce.
    function automatic out_item_t advance_axis(in_item_t it);
        out_item_t   r;
        logic [31:0] need;
        r = '0;
        case (it.action)
            ACT_START:
            begin
                if (ax_phase == PH_IDLE && it.step_total != 0 && !ax_alarm)
                begin
                    ax_dir    = it.move_dir;
                    ax_goal   = it.step_total;
                    ax_done   = '0;
                    ax_phase  = PH_ACCEL;
                    ax_period = reg_max;
                    need      = '0;
                    if (reg_max > reg_min && reg_chg != 0)
                        need = ((32'(reg_max) - 32'(reg_min)) / 32'(reg_chg)) * 2;
                    // The ramp can take at most half of the move.
                    if (64'(need) * 2 > 64'(it.step_total))
                        ax_ramp = it.step_total >> 1;
                    else
                        ax_ramp = need;
                    ax_decel   = it.step_total - ax_ramp;
                    r.accepted = 1'b1;
                end
            end
            ACT_CLEAR:
                ax_alarm = 1'b0;
            ACT_ZERO:
                ax_pos = '0;
            default:
            begin
                if (ax_phase != PH_IDLE)
                begin
                    if (it.limit_switch && ax_dir)
                    begin
                        ax_alarm      = 1'b1;
                        r.flush_queue = 1'b1;
                        r.stop_cause  = CAUSE_LIMIT;
                        ax_phase      = PH_IDLE;
                    end
                    else if (it.home_switch && !ax_dir)
                    begin
                        ax_phase     = PH_IDLE;
                        r.stop_cause = CAUSE_HOME;
                        if (!reg_homing)
                        begin
                            ax_alarm      = 1'b1;
                            r.flush_queue = 1'b1;
                        end
                    end
                    else
                    begin
                        ax_done = ax_done + 1;
                        ax_pos  = ax_dir ? ax_pos + 1 : ax_pos - 1;
                        if (ax_done >= ax_goal)
                        begin
                            ax_phase     = PH_IDLE;
                            r.move_done  = 1'b1;
                            r.stop_cause = CAUSE_TARGET;
                        end
                        else
                            ramp_period();
                    end
                end
            end
        endcase
        r.phase         = ax_phase;
        r.timer_period  = ax_period;
        r.pulse_compare = ax_period[15:1];
        r.axis_position = ax_pos;
        r.alarm         = ax_alarm;
        return r;
    endfunction

    function automatic string describe(out_item_t r);
        return {$sformatf("acc=%0d phase=%0d period=%0d cmp=%0d pos=%0d ",
                          r.accepted, r.phase, r.timer_period, r.pulse_compare,
                          r.axis_position),
                $sformatf("alarm=%0d done=%0d cause=%0d flush=%0d",
                          r.alarm, r.move_done, r.stop_cause, r.flush_queue)};
    endfunction

    // Sender side: inputs change on the falling edge. The idle rates follow
    // three regimes: receiver sparse, then sender sparse, then full speed.
    always @(negedge clk)
    begin : driver
        in_item_t next_item;
        logic     next_valid;
        int       send_idle;
        int       recv_idle;
        if (items_sent < 290)
        begin
            send_idle = 36;
            recv_idle = 70;
        end
        else if (items_sent < 580)
        begin
            send_idle = 70;
            recv_idle = 36;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        next_valid = in_valid;
        next_item  = in_data;
        if (in_valid && in_taken)
            next_valid = 1'b0;
        if (rst_n && !next_valid && pending_items.size() > 0
            && $urandom_range(0, 99) >= send_idle)
        begin
            next_item  = pending_items.pop_front();
            next_valid = 1'b1;
            items_sent = items_sent + 1;
        end
        in_valid  <= next_valid;
        in_data   <= next_item;
        out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // Everything that happens at a rising edge: register writes reach the
    // shadow configuration, accepted transfers are predicted, and result
    // transfers are checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PERIOD_MIN:    reg_min    = cfg_data;
                    CFG_PERIOD_MAX:    reg_max    = cfg_data;
                    CFG_PERIOD_CHANGE: reg_chg    = cfg_data;
                    CFG_HOMING_MODE:   reg_homing = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                axis_results_due.push_back(advance_axis(in_data));
            if (out_valid && !out_stall)
            begin
                if (axis_results_due.size() == 0)
                begin
                    fault_count = fault_count + 1;
                    if (fault_count <= 10)
                        $display("%0t: result with nothing pending: %s", $realtime,
                                 describe(out_data));
                end
                else
                begin
                    want = axis_results_due.pop_front();
                    if (out_data !== want)
                    begin
                        fault_count = fault_count + 1;
                        if (fault_count <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(out_data));
                        end
                    end
                end
            end
        end
    end

    function automatic in_item_t make_item(action_t a, logic [31:0] n, logic d,
                                           logic h, logic l);
        in_item_t it;
        it.action       = a;
        it.step_total   = n;
        it.move_dir     = d;
        it.home_switch  = h;
        it.limit_switch = l;
        return it;
    endfunction

    // Queues well-formed moves with random content, mixed with some noise.
    task automatic plan_moves(int budget);
        int          left;
        int          n_ticks;
        int          k;
        logic [31:0] steps;
        logic        d;
        logic        huge;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                pending_items.push_back(make_item(action_t'($urandom_range(0, 3)), $urandom,
                                                  1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))));
                left = left - 1;
            end
            else
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    pending_items.push_back(make_item(ACT_CLEAR, $urandom,
                                                      1'($urandom_range(0, 1)),
                                                      1'($urandom_range(0, 1)),
                                                      1'($urandom_range(0, 1))));
                    left = left - 1;
                end
                d     = 1'($urandom_range(0, 1));
                huge  = ($urandom_range(0, 99) < 8);
                steps = huge ? $urandom : $urandom_range(1, 40);
                pending_items.push_back(make_item(ACT_START, steps, d,
                                                  1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))));
                left    = left - 1;
                n_ticks = huge ? $urandom_range(0, 15) : steps + $urandom_range(0, 2);
                for (k = 0; k < n_ticks; k++)
                begin
                    if ($urandom_range(0, 99) < 2)
                        pending_items.push_back(make_item(ACT_ZERO, $urandom, d, 1'b0, 1'b0));
                    else if ($urandom_range(0, 99) < 2)
                        pending_items.push_back(make_item(ACT_START, $urandom,
                                                          1'($urandom_range(0, 1)),
                                                          1'b0, 1'b0));
                    else
                        pending_items.push_back(make_item(ACT_TICK, $urandom,
                                                          1'($urandom_range(0, 1)),
                                                          $urandom_range(0, 99) < 3,
                                                          $urandom_range(0, 99) < 3));
                    left = left - 1;
                end
                // A very long move is ended by a switch that stops either direction.
                if (huge)
                begin
                    pending_items.push_back(make_item(ACT_TICK, $urandom, d, 1'b1, 1'b1));
                    left = left - 1;
                end
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || in_valid || axis_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic program_axis(logic [15:0] pmin, logic [15:0] pmax, logic [15:0] pchg,
                                logic homing);
        write_reg(CFG_PERIOD_MIN, pmin);
        write_reg(CFG_PERIOD_MAX, pmax);
        write_reg(CFG_PERIOD_CHANGE, pchg);
        write_reg(CFG_HOMING_MODE, {15'd0, homing});
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int          p;
        logic [15:0] base;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset configuration.
        // An idle tick with both switches active changes nothing.
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b1, 1'b1, 1'b1));
        // A start with no steps is refused.
        pending_items.push_back(make_item(ACT_START, 32'd0, 1'b1, 1'b0, 1'b0));
        // Short positive move; the ramp is capped at half of it.
        pending_items.push_back(make_item(ACT_START, 32'd4, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_START, 32'd5, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
        // Negative move: the limit switch is ignored, the home switch stops it.
        pending_items.push_back(make_item(ACT_START, 32'd3, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b1, 1'b0, 1'b1));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b1, 1'b1, 1'b0));
        // The alarm blocks a start until cleared.
        pending_items.push_back(make_item(ACT_START, 32'd2, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        // Longest move, stopped by the limit switch.
        pending_items.push_back(make_item(ACT_START, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b1, 1'b0, 1'b1));
        pending_items.push_back(make_item(ACT_ZERO, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_CLEAR, 32'd0, 1'b0, 1'b0, 1'b0));
        // Zero position and clear alarm during a move let the move go on.
        pending_items.push_back(make_item(ACT_START, 32'd2, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_ZERO, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_CLEAR, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
        pending_items.push_back(make_item(ACT_TICK, 32'd0, 1'b0, 1'b0, 1'b0));
        plan_moves(95);

        // Each later phase reprograms the axis once the block has gone quiet.
        for (p = 0; p < 7; p++)
        begin
            wait_for_drain();
            case (p)
                // Both saturations: subtraction below zero, addition past the top.
                0: program_axis(16'd1, 16'hFFFF, 16'd40000, 1'b0);
                1: program_axis(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                // Maximum below minimum: no ramp at all.
                2: program_axis(16'd300, 16'd100, 16'd7, 1'b1);
                // No period change: the period never moves.
                3: program_axis(16'd50, 16'd400, 16'd0, 1'b0);
                // Short ramp, so moves reach the cruise phase.
                4: program_axis(16'd200, 16'd230, 16'd5, 1'b1);
                5:
                begin
                    base = 16'($urandom_range(1, 3000));
                    program_axis(base, base + 16'($urandom_range(0, 120)),
                                 16'($urandom_range(1, 20)), 1'($urandom_range(0, 1)));
                end
                default: program_axis(16'd1, 16'd1, 16'd1, 1'b0);
            endcase
            plan_moves(95);
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && axis_results_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/stp_ramp_pkg.sv
sv/stepper_trapezoid_ramp.sv
tb/sv/testbench.sv
